/* rtl/ps2mpct_pkg.sv */
// shared types, constants and the helper function of the ps/2 mouse packet cursor tracker
`default_nettype none

package ps2mpct_pkg;

   // position and limit widths
   localparam int POS_BITS      = 12;
   localparam int CFG_BITS      = 12;
   localparam int WIDE_BITS     = ((POS_BITS > CFG_BITS) ? POS_BITS : CFG_BITS) + 2;
   localparam int POS_MAX_VAL   = (1 << POS_BITS) - 1;
   localparam int POS_RESET_VAL = (400 > POS_MAX_VAL) ? POS_MAX_VAL : 400;

   // register reset values
   localparam logic [CFG_BITS-1:0] X_LIMIT_RESET = CFG_BITS'(800 - 2);
   localparam logic [CFG_BITS-1:0] Y_LIMIT_RESET = CFG_BITS'(600 - 4);

   // byte codes of the mouse stream
   localparam logic [7:0] ACK_BYTE   = 8'hFA;
   localparam logic [7:0] SYNC_MASK  = 8'hC8;
   localparam logic [7:0] SYNC_VALUE = 8'h08;

   // header bit positions
   localparam int HDR_X_SIGN = 4;
   localparam int HDR_Y_SIGN = 5;

   // csr port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [0:0] {
      CSR_X_LIMIT = 1'b0,
      CSR_Y_LIMIT = 1'b1
   } csr_index_type;

   // packet framing phase
   typedef enum logic [1:0] {
      PH_WAIT_ACK = 2'd0,
      PH_HEADER   = 2'd1,
      PH_X        = 2'd2,
      PH_Y        = 2'd3
   } phase_type;

   // one decoded packet from the framer
   typedef struct packed {
      logic              done;
      logic [2:0]        buttons;
      logic signed [8:0] move_x;
      logic signed [9:0] move_y;
   } packet_type;

   // add a move to a position, clamp to zero and to the limit (itself capped to the range)
   function automatic logic [WIDE_BITS-1:0] clamp_pos(
      input logic [POS_BITS-1:0] pos,
      input logic signed [9:0]   move,
      input logic [CFG_BITS-1:0] limit
   );
      logic signed [WIDE_BITS-1:0] sum;
      logic signed [WIDE_BITS-1:0] lim;
      logic signed [WIDE_BITS-1:0] pmax;
      logic [WIDE_BITS-1:0]        res;
      sum  = signed'(WIDE_BITS'(pos)) + WIDE_BITS'(move);
      lim  = signed'(WIDE_BITS'(limit));
      pmax = signed'(WIDE_BITS'(POS_MAX_VAL));
      if (lim > pmax) begin
         lim = pmax;
      end
      if (sum < 0) begin
         res = '0;
      end else if (sum > lim) begin
         res = lim;
      end else begin
         res = sum;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/ps2mpct_framer.sv */
// packet framer: waits for acknowledge, checks header sync, splits out buttons and moves
`default_nettype none

module ps2mpct_framer
   import ps2mpct_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       take,
   input  wire logic [7:0] rx_byte,
   output logic            last_byte,
   output packet_type      pkt
);

   phase_type  phase_ff, phase_in;
   logic [7:0] header_ff, header_in;
   logic [7:0] xbyte_ff, xbyte_in;

   // next phase and byte capture
   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      xbyte_in  = xbyte_ff;
      if (take) begin
         case (phase_ff)
            PH_WAIT_ACK: begin
               if (rx_byte == ACK_BYTE) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_HEADER: begin
               if ((rx_byte & SYNC_MASK) == SYNC_VALUE) begin
                  header_in = rx_byte;
                  phase_in  = PH_X;
               end
            end
            PH_X: begin
               xbyte_in = rx_byte;
               phase_in = PH_Y;
            end
            PH_Y: begin
               phase_in = PH_HEADER;
            end
            default: begin
               phase_in = PH_WAIT_ACK;
            end
         endcase
      end
   end

   // packet decode on the third byte
   always_comb begin
      last_byte      = (phase_ff == PH_Y);
      pkt.done       = take && last_byte;
      pkt.buttons    = header_ff[2:0];
      pkt.move_x     = signed'({header_ff[HDR_X_SIGN], xbyte_ff});
      pkt.move_y     = 10'sd0 - signed'({header_ff[HDR_Y_SIGN], header_ff[HDR_Y_SIGN], rx_byte});
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT_ACK;
         header_ff <= '0;
         xbyte_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         xbyte_ff  <= xbyte_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/ps2mpct_cursor.sv */
// cursor position keeper: adds packet moves and clamps to zero and the limits
`default_nettype none

module ps2mpct_cursor
   import ps2mpct_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire packet_type          pkt,
   input  wire logic [CFG_BITS-1:0] x_limit,
   input  wire logic [CFG_BITS-1:0] y_limit,
   output logic [CFG_BITS-1:0]      new_x,
   output logic [CFG_BITS-1:0]      new_y
);

   logic [POS_BITS-1:0]  pos_x_ff, pos_x_in;
   logic [POS_BITS-1:0]  pos_y_ff, pos_y_in;
   logic [WIDE_BITS-1:0] sum_x;
   logic [WIDE_BITS-1:0] sum_y;

   // clamped positions after this packet
   always_comb begin
      sum_x    = clamp_pos(pos_x_ff, 10'(pkt.move_x), x_limit);
      sum_y    = clamp_pos(pos_y_ff, pkt.move_y, y_limit);
      pos_x_in = pkt.done ? sum_x[POS_BITS-1:0] : pos_x_ff;
      pos_y_in = pkt.done ? sum_y[POS_BITS-1:0] : pos_y_ff;
      new_x    = sum_x[CFG_BITS-1:0];
      new_y    = sum_y[CFG_BITS-1:0];
   end

   // position registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff <= POS_BITS'(POS_RESET_VAL);
         pos_y_ff <= POS_BITS'(POS_RESET_VAL);
      end else begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/ps2mpct_csr.sv */
// csr block: cursor limit registers behind an apb-style port
`default_nettype none

module ps2mpct_csr
   import ps2mpct_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic [CFG_BITS-1:0]           x_limit,
   output logic [CFG_BITS-1:0]           y_limit
);

   logic [CFG_BITS-1:0] x_limit_ff, x_limit_in;
   logic [CFG_BITS-1:0] y_limit_ff, y_limit_in;
   csr_index_type       index;
   logic                wr_en;

   // register writes
   always_comb begin
      index      = csr_index_type'(paddr[2]);
      wr_en      = psel && penable && pwrite;
      x_limit_in = x_limit_ff;
      y_limit_in = y_limit_ff;
      if (wr_en) begin
         case (index)
            CSR_X_LIMIT: x_limit_in = pwdata[CFG_BITS-1:0];
            CSR_Y_LIMIT: y_limit_in = pwdata[CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // read data
   always_comb begin
      case (index)
         CSR_X_LIMIT: prdata = CSR_DATA_BITS'(x_limit_ff);
         CSR_Y_LIMIT: prdata = CSR_DATA_BITS'(y_limit_ff);
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_limit_ff <= X_LIMIT_RESET;
         y_limit_ff <= Y_LIMIT_RESET;
      end else begin
         x_limit_ff <= x_limit_in;
         y_limit_ff <= y_limit_in;
      end
   end

   assign x_limit = x_limit_ff;
   assign y_limit = y_limit_ff;

endmodule

`default_nettype wire

/* rtl/ps2_mouse_packet_cursor_tracker.sv */
// top level: ps/2 mouse byte stream in, decoded packets with cursor position out
//
// Raw mouse bytes enter on the req_ channel (req_rx_byte), one per transaction.
// After reset the block waits for the 0xFA acknowledge, then frames three-byte
// packets; a header byte without the sync pattern is dropped. The third byte of
// each packet gives one transaction on the rsp_ channel: buttons, the signed X
// move, the negated Y move and the clamped cursor position.
// The result is registered and shown the cycle after the third byte is taken.
// Throughput: one byte per cycle when no held result stalls; framing, sign
// handling and the clamp adders sit between the framing registers and the
// result register. When the receiver stalls, the result register holds its
// transaction and the block keeps accepting header and X bytes; only a third
// byte waits in req_ until the held result has been taken.
// Reset (synchronous) returns to waiting for acknowledge, puts the cursor at
// 400/400 and the limits to 798/596. The limits sit at csr_ address 0 (X) and
// 4 (Y); csr_pready is always high.
`default_nettype none

module ps2_mouse_packet_cursor_tracker
   import ps2mpct_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [7:0]               req_rx_byte,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [2:0]                    rsp_buttons,
   output logic signed [8:0]             rsp_move_x,
   output logic signed [9:0]             rsp_move_y,
   output logic [CFG_BITS-1:0]           rsp_cursor_x,
   output logic [CFG_BITS-1:0]           rsp_cursor_y,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                          csr_pready
);

   logic                take;
   logic                last_byte;
   packet_type          pkt;
   logic [CFG_BITS-1:0] x_limit;
   logic [CFG_BITS-1:0] y_limit;
   logic [CFG_BITS-1:0] new_x;
   logic [CFG_BITS-1:0] new_y;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          buttons_ff;
   logic signed [8:0]   move_x_ff;
   logic signed [9:0]   move_y_ff;
   logic [CFG_BITS-1:0] cursor_x_ff;
   logic [CFG_BITS-1:0] cursor_y_ff;

   ps2mpct_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .x_limit (x_limit),
      .y_limit (y_limit)
   );

   ps2mpct_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .rx_byte   (req_rx_byte),
      .last_byte (last_byte),
      .pkt       (pkt)
   );

   ps2mpct_cursor u_cursor (
      .clock   (clock),
      .reset   (reset),
      .pkt     (pkt),
      .x_limit (x_limit),
      .y_limit (y_limit),
      .new_x   (new_x),
      .new_y   (new_y)
   );

   // input handshake: only a result-making byte waits behind a held result
   always_comb begin
      req_stall    = rsp_valid_ff && rsp_stall && last_byte;
      take         = req_valid && !req_stall;
      rsp_valid_in = pkt.done || (rsp_valid_ff && rsp_stall);
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (pkt.done) begin
         buttons_ff  <= pkt.buttons;
         move_x_ff   <= pkt.move_x;
         move_y_ff   <= pkt.move_y;
         cursor_x_ff <= new_x;
         cursor_y_ff <= new_y;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_buttons  = buttons_ff;
   assign rsp_move_x   = move_x_ff;
   assign rsp_move_y   = move_y_ff;
   assign rsp_cursor_x = cursor_x_ff;
   assign rsp_cursor_y = cursor_y_ff;
   assign csr_pready   = 1'b1;

   // a third byte taken always yields a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (take && last_byte) |=> rsp_valid)
      else $error("packet result missing");

   // input waits only behind a held result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   // a held result is never overwritten by a new packet
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !pkt.done)
      else $error("held result overwritten");

   // the vertical move stays within the negated byte range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_move_y != -10'sd256 && rsp_move_y != -10'sd257))
      else $error("vertical move out of range");

endmodule

`default_nettype wire
